// ===== hdl/tsqe_pkg.sv =====
// Shared constants and controller/datapath interface types for the thick stroke quad expander.
`default_nettype none
package tsqe_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int HT_W           = 14;
  localparam logic [HT_W-1:0] HT_RESET = 14'd33;
  localparam int NORM_W         = 16;  // Q1.14 normal width; also the width of the integer edge offsets
  localparam int MAG_W          = 16;  // magnitude width after range reduction
  localparam int SQ_W           = 2 * MAG_W;
  localparam int S_W            = SQ_W + 1;
  localparam int Q_W            = 15;  // unit magnitude, 0..16384
  localparam int ACC_W          = 67;  // signed width of the root search terms
  localparam int FRAC_BITS      = 14;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_END   = 1'b1;

  localparam logic REG_HALF_THICKNESS = 1'b0;

  localparam logic [1:0] VTX_LAST = 2'd3;

  typedef struct packed {
    logic       store_first;
    logic       load_seg;
    logic       norm_shift;
    logic       square;
    logic       sum;
    logic       lane_start;
    logic       take_normal;
    logic       take_offset;
    logic       emit;
    logic       commit;
    logic [1:0] vtx;
  } tsqe_cmd_t;

  typedef struct packed {
    logic same_point;
    logic norm_big;
    logic lanes_busy;
    logic out_free;
  } tsqe_stat_t;

endpackage
`default_nettype wire

// ===== hdl/thick_stroke_quad_expander.sv =====
// Thick stroke quad expander: top level with configuration register and block wiring.
//
// Input channel (in_*): one word per pen point or end-of-stroke mark, valid/ready.
// Output channel (out_*): vertex words, four per segment, valid/ready; the fourth
// carries out_last_vertex. A one-word output register separates the two sides.
// Configuration: APB-style port (cfg_*), half_thickness at byte address 0, pready
// always high; the user writes only while the block is idle, unenforced by the block.
// Sequencing: an end mark, a first point or a repeated point is handled in the idle
// state. A new segment point passes through setup (load, one range-reduction
// shift per bit that the coordinate difference exceeds 16 bits, square, sum,
// start), the two magnitude search units (15 result bits, one at a time), the
// normal and the offset, then vertex output. The next word is accepted once the
// fourth vertex is in the output register.
// Reset: no stroke open, stored point cleared of meaning, half_thickness = 33.
// A stalled receiver holds the output word and the vertex sequence; input is
// not accepted until all four vertices have been loaded.
`default_nettype none
module thick_stroke_quad_expander #(
  parameter int COORD_BITS = tsqe_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [2:0]                    cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_kind,
  input  wire logic signed [COORD_BITS-1:0]  in_point_x,
  input  wire logic signed [COORD_BITS-1:0]  in_point_y,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_BITS-1:0]       out_vertex_x,
  output logic signed [COORD_BITS-1:0]       out_vertex_y,
  output logic signed [tsqe_pkg::NORM_W-1:0] out_normal_x,
  output logic signed [tsqe_pkg::NORM_W-1:0] out_normal_y,
  output logic                               out_last_vertex
);

  logic [tsqe_pkg::HT_W-1:0] ht_r;
  logic                      sel_ht;
  tsqe_pkg::tsqe_cmd_t       cmd;
  tsqe_pkg::tsqe_stat_t      stat;

  assign sel_ht     = (cfg_paddr[2] == tsqe_pkg::REG_HALF_THICKNESS);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = sel_ht ? 32'(ht_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ht_r <= tsqe_pkg::HT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && sel_ht) begin
      ht_r <= cfg_pwdata[tsqe_pkg::HT_W-1:0];
    end
  end

  tsqe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tsqe_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .half_thickness  (ht_r),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_vertex_x    (out_vertex_x),
    .out_vertex_y    (out_vertex_y),
    .out_normal_x    (out_normal_x),
    .out_normal_y    (out_normal_y),
    .out_last_vertex (out_last_vertex)
  );

endmodule
`default_nettype wire

// ===== hdl/tsqe_umag.sv =====
// Iterative unit-component magnitude search, one result bit per iteration.
`default_nettype none
module tsqe_umag (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [tsqe_pkg::SQ_W-1:0] d_sq,
  input  wire logic [tsqe_pkg::S_W-1:0]  s,
  output logic                           busy,
  output logic [tsqe_pkg::Q_W-1:0]       mag
);

  localparam int W = tsqe_pkg::ACC_W;

  logic                    busy_r;
  logic                    phase_r;
  logic [tsqe_pkg::Q_W-1:0] mask_r;
  logic [tsqe_pkg::Q_W-1:0] q_r;
  logic signed [W-1:0]     a_r, b_r, sk_r, e_r, rhs_r;

  logic signed [W-1:0]     s_ext, b_sum;
  logic                    acc;

  // a: (2q-1)^2*s, b: (2q-1)*s << (k+2), sk: s << (2k+2)
  always_comb begin
    s_ext = signed'(W'(s));
    acc   = (e_r <= rhs_r) && !q_r[tsqe_pkg::Q_W-1];
    b_sum = acc ? (b_r + (sk_r <<< 1)) : b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
    end else if (start) begin
      busy_r  <= 1'b1;
      phase_r <= 1'b0;
    end else if (busy_r) begin
      phase_r <= ~phase_r;
      if (phase_r && mask_r[0]) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= s_ext;
      b_r    <= -(s_ext <<< 16);
      sk_r   <= s_ext <<< 30;
      rhs_r  <= signed'(W'(d_sq)) <<< 30;
      q_r    <= '0;
      mask_r <= {1'b1, {(tsqe_pkg::Q_W-1){1'b0}}};
    end else if (busy_r) begin
      if (!phase_r) begin
        e_r <= a_r + b_r + sk_r;
      end else begin
        if (acc) begin
          q_r <= q_r | mask_r;
          a_r <= e_r;
        end
        b_r    <= b_sum >>> 1;
        sk_r   <= sk_r >>> 2;
        mask_r <= mask_r >> 1;
      end
    end
  end

  assign busy = busy_r;
  assign mag  = q_r;

endmodule
`default_nettype wire

// ===== hdl/tsqe_dp.sv =====
// Datapath: stored point, magnitude reduction, squares, normals, offsets and output word.
`default_nettype none
module tsqe_dp #(
  parameter int COORD_BITS = tsqe_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tsqe_pkg::tsqe_cmd_t               cmd,
  output tsqe_pkg::tsqe_stat_t                   stat,
  input  wire logic [tsqe_pkg::HT_W-1:0]         half_thickness,
  input  wire logic signed [COORD_BITS-1:0]      in_point_x,
  input  wire logic signed [COORD_BITS-1:0]      in_point_y,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [COORD_BITS-1:0]           out_vertex_x,
  output logic signed [COORD_BITS-1:0]           out_vertex_y,
  output logic signed [tsqe_pkg::NORM_W-1:0]     out_normal_x,
  output logic signed [tsqe_pkg::NORM_W-1:0]     out_normal_y,
  output logic                                   out_last_vertex
);

  localparam int NW = tsqe_pkg::NORM_W;
  localparam int AW = (COORD_BITS > tsqe_pkg::MAG_W) ? COORD_BITS : tsqe_pkg::MAG_W;
  localparam int SW = AW + 1;
  localparam int PW = NW + tsqe_pkg::HT_W + 1;
  localparam logic signed [SW-1:0] SAT_HI =
    {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO =
    {{(SW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic [AW-1:0]                ax_r, ay_r;
  logic                         neg_x_r, neg_y_r;
  logic [tsqe_pkg::SQ_W-1:0]    ax2_r, ay2_r;
  logic [tsqe_pkg::S_W-1:0]     s_r;
  logic signed [NW-1:0]         nx_r, ny_r, ox_r, oy_r;
  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] vx_r, vy_r;
  logic signed [NW-1:0]         vnx_r, vny_r;
  logic                         vlast_r;

  logic signed [COORD_BITS:0]   dx, dy, mx, my;
  logic [tsqe_pkg::Q_W-1:0]     ux, uy;
  logic                         busy_x, busy_y;
  logic signed [PW-1:0]         prod_x, prod_y, offs_x, offs_y;
  logic signed [COORD_BITS-1:0] base_x, base_y;
  logic signed [NW-1:0]         off_x, off_y, vn_x, vn_y;
  logic signed [SW-1:0]         sum_x, sum_y, sat_x, sat_y;

  always_comb begin
    dx = (COORD_BITS+1)'(in_point_x) - (COORD_BITS+1)'(prev_x_r);
    dy = (COORD_BITS+1)'(in_point_y) - (COORD_BITS+1)'(prev_y_r);
    mx = dx[COORD_BITS] ? -dx : dx;
    my = dy[COORD_BITS] ? -dy : dy;

    prod_x = nx_r * signed'({1'b0, half_thickness});
    prod_y = ny_r * signed'({1'b0, half_thickness});
    offs_x = (prod_x + PW'(8192)) >>> tsqe_pkg::FRAC_BITS;
    offs_y = (prod_y + PW'(8192)) >>> tsqe_pkg::FRAC_BITS;

    base_x = cmd.vtx[1] ? cur_x_r : prev_x_r;
    base_y = cmd.vtx[1] ? cur_y_r : prev_y_r;
    off_x  = cmd.vtx[0] ? -ox_r : ox_r;
    off_y  = cmd.vtx[0] ? -oy_r : oy_r;
    vn_x   = cmd.vtx[0] ? -nx_r : nx_r;
    vn_y   = cmd.vtx[0] ? -ny_r : ny_r;
    sum_x  = SW'(base_x) + SW'(off_x);
    sum_y  = SW'(base_y) + SW'(off_y);
    sat_x  = (sum_x > SAT_HI) ? SAT_HI : ((sum_x < SAT_LO) ? SAT_LO : sum_x);
    sat_y  = (sum_y > SAT_HI) ? SAT_HI : ((sum_y < SAT_LO) ? SAT_LO : sum_y);

    stat.same_point = (in_point_x == prev_x_r) && (in_point_y == prev_y_r);
    stat.norm_big   = (|(ax_r >> tsqe_pkg::MAG_W)) || (|(ay_r >> tsqe_pkg::MAG_W));
    stat.lanes_busy = busy_x || busy_y;
    stat.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.store_first) begin
      prev_x_r <= in_point_x;
      prev_y_r <= in_point_y;
    end else if (cmd.commit) begin
      prev_x_r <= cur_x_r;
      prev_y_r <= cur_y_r;
    end
    if (cmd.load_seg) begin
      cur_x_r <= in_point_x;
      cur_y_r <= in_point_y;
      ax_r    <= AW'(mx[COORD_BITS-1:0]);
      ay_r    <= AW'(my[COORD_BITS-1:0]);
      neg_x_r <= dx[COORD_BITS];
      neg_y_r <= dy[COORD_BITS];
    end else if (cmd.norm_shift) begin
      ax_r <= ax_r >> 1;
      ay_r <= ay_r >> 1;
    end
    if (cmd.square) begin
      ax2_r <= ax_r[tsqe_pkg::MAG_W-1:0] * ax_r[tsqe_pkg::MAG_W-1:0];
      ay2_r <= ay_r[tsqe_pkg::MAG_W-1:0] * ay_r[tsqe_pkg::MAG_W-1:0];
    end
    if (cmd.sum) begin
      s_r <= tsqe_pkg::S_W'(ax2_r) + tsqe_pkg::S_W'(ay2_r);
    end
    if (cmd.take_normal) begin
      nx_r <= neg_y_r ? signed'(NW'(uy)) : -signed'(NW'(uy));
      ny_r <= neg_x_r ? -signed'(NW'(ux)) : signed'(NW'(ux));
    end
    if (cmd.take_offset) begin
      ox_r <= offs_x[NW-1:0];
      oy_r <= offs_y[NW-1:0];
    end
    if (cmd.emit) begin
      vx_r    <= sat_x[COORD_BITS-1:0];
      vy_r    <= sat_y[COORD_BITS-1:0];
      vnx_r   <= vn_x;
      vny_r   <= vn_y;
      vlast_r <= (cmd.vtx == tsqe_pkg::VTX_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  tsqe_umag u_mag_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.lane_start),
    .d_sq  (ax2_r),
    .s     (s_r),
    .busy  (busy_x),
    .mag   (ux)
  );

  tsqe_umag u_mag_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.lane_start),
    .d_sq  (ay2_r),
    .s     (s_r),
    .busy  (busy_y),
    .mag   (uy)
  );

  assign out_valid       = out_valid_r;
  assign out_vertex_x    = vx_r;
  assign out_vertex_y    = vy_r;
  assign out_normal_x    = vnx_r;
  assign out_normal_y    = vny_r;
  assign out_last_vertex = vlast_r;

endmodule
`default_nettype wire

// ===== hdl/tsqe_ctrl.sv =====
// Controller: stroke state and sequencing of one point through the datapath.
`default_nettype none
module tsqe_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_kind,
  output logic                      in_ready,
  input  wire tsqe_pkg::tsqe_stat_t stat,
  output tsqe_pkg::tsqe_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_SUM,
    ST_START,
    ST_ITER,
    ST_OFFS,
    ST_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  logic       open_r, open_nxt;
  logic       seg_r, seg_nxt;
  logic [1:0] vtx_r, vtx_nxt;
  logic       take;

  always_comb begin
    take      = in_valid && (state_r == ST_IDLE);
    cmd       = '0;
    cmd.vtx   = vtx_r;
    state_nxt = state_r;
    open_nxt  = open_r;
    seg_nxt   = seg_r;
    vtx_nxt   = vtx_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (in_kind == tsqe_pkg::KIND_END) begin
            if (seg_r) begin
              open_nxt = 1'b0;
              seg_nxt  = 1'b0;
            end
          end else if (!open_r) begin
            cmd.store_first = 1'b1;
            open_nxt        = 1'b1;
            seg_nxt         = 1'b0;
          end else if (!stat.same_point) begin
            cmd.load_seg = 1'b1;
            state_nxt    = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (stat.norm_big) begin
          cmd.norm_shift = 1'b1;
        end else begin
          cmd.square = 1'b1;
          state_nxt  = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_START;
      end
      ST_START: begin
        cmd.lane_start = 1'b1;
        state_nxt      = ST_ITER;
      end
      ST_ITER: begin
        if (!stat.lanes_busy) begin
          cmd.take_normal = 1'b1;
          state_nxt       = ST_OFFS;
        end
      end
      ST_OFFS: begin
        cmd.take_offset = 1'b1;
        vtx_nxt         = '0;
        state_nxt       = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (vtx_r == tsqe_pkg::VTX_LAST) begin
            cmd.commit = 1'b1;
            seg_nxt    = 1'b1;
            state_nxt  = ST_IDLE;
          end
          vtx_nxt = vtx_r + 2'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      open_r  <= 1'b0;
      seg_r   <= 1'b0;
      vtx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      open_r  <= open_nxt;
      seg_r   <= seg_nxt;
      vtx_r   <= vtx_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule
`default_nettype wire

// ===== bench/tsqe_vertex_checker.sv =====
// Vertex checker for the thick stroke quad expander: predicts each quad and compares output words.
`timescale 1ns / 1ps
module tsqe_vertex_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_kind,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_vertex_x,
  input  logic signed [15:0] out_vertex_y,
  input  logic signed [15:0] out_normal_x,
  input  logic signed [15:0] out_normal_y,
  input  logic               out_last_vertex,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic               last;
  } vertex_t;

  vertex_t                   vertex_q[$];
  vertex_t                   want;
  logic [tsqe_pkg::HT_W-1:0] half_thick;
  logic signed [15:0]        anchor_x;
  logic signed [15:0]        anchor_y;
  logic                      stroke_open;
  logic                      seg_done;
  int                        fails = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // rounded magnitude of one unit-vector component, 0..16384
  function automatic longint unsigned unit_root(input longint unsigned d,
                                                input longint unsigned s);
    longint unsigned q, c, t, rhs;
    int b;
    q   = 0;
    rhs = (d * d) << 30;
    for (b = 14; b >= 0; b--) begin
      c = q | (64'd1 << b);
      t = 2 * c - 1;
      if (c <= 16384 && t * t * s <= rhs) q = c;
    end
    return q;
  endfunction

  function automatic longint edge_offset(input longint n, input longint h);
    return (n * h + 8192) >>> 14;
  endfunction

  function automatic logic signed [15:0] clamp_coord(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic vertex_t corner(input longint px, py, ox, oy, nx, ny, input logic last);
    vertex_t v;
    v.vx   = clamp_coord(px + ox);
    v.vy   = clamp_coord(py + oy);
    v.nx   = 16'(nx);
    v.ny   = 16'(ny);
    v.last = last;
    return v;
  endfunction

  task automatic expect_quad(input longint x, input longint y);
    longint dx, dy, ax, ay, s, ux, uy, nx, ny, ox, oy;
    dx = x - anchor_x;
    dy = y - anchor_y;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    while (ax >= 65536 || ay >= 65536) begin
      ax = ax >> 1;
      ay = ay >> 1;
    end
    s  = ax * ax + ay * ay;
    ux = unit_root(ax, s);
    uy = unit_root(ay, s);
    nx = (dy < 0) ? uy : -uy;
    ny = (dx < 0) ? -ux : ux;
    ox = edge_offset(nx, half_thick);
    oy = edge_offset(ny, half_thick);
    vertex_q = {vertex_q, corner(anchor_x, anchor_y, ox, oy, nx, ny, 1'b0)};
    vertex_q = {vertex_q, corner(anchor_x, anchor_y, -ox, -oy, -nx, -ny, 1'b0)};
    vertex_q = {vertex_q, corner(x, y, ox, oy, nx, ny, 1'b0)};
    vertex_q = {vertex_q, corner(x, y, -ox, -oy, -nx, -ny, 1'b1)};
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      half_thick  = tsqe_pkg::HT_RESET;
      anchor_x    = '0;
      anchor_y    = '0;
      stroke_open = 1'b0;
      seg_done    = 1'b0;
      vertex_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == tsqe_pkg::REG_HALF_THICKNESS)
        half_thick = cfg_pwdata[tsqe_pkg::HT_W-1:0];

      if (out_valid && out_ready) begin
        if (vertex_q.size() == 0) begin
          $error("vertex word with no quad outstanding: x=%0d y=%0d", out_vertex_x,
                 out_vertex_y);
          fails++;
        end else begin
          want = vertex_q.pop_front();
          check_field("vertex_x", want.vx, out_vertex_x);
          check_field("vertex_y", want.vy, out_vertex_y);
          check_field("normal_x", want.nx, out_normal_x);
          check_field("normal_y", want.ny, out_normal_y);
          check_field("last_vertex", want.last, out_last_vertex);
        end
      end

      if (in_valid && in_ready) begin
        if (in_kind == tsqe_pkg::KIND_END) begin
          if (seg_done) begin
            stroke_open = 1'b0;
            seg_done    = 1'b0;
          end
        end else if (!stroke_open) begin
          anchor_x    = in_point_x;
          anchor_y    = in_point_y;
          stroke_open = 1'b1;
          seg_done    = 1'b0;
        end else if (in_point_x != anchor_x || in_point_y != anchor_y) begin
          expect_quad(in_point_x, in_point_y);
          anchor_x = in_point_x;
          anchor_y = in_point_y;
          seg_done = 1'b1;
        end
      end
    end
    fail_count <= fails;
    pending    <= vertex_q.size();
  end

endmodule

// ===== bench/tb_thick_stroke_quad_expander.sv =====
// Testbench top for the thick stroke quad expander: clock, reset, stroke traffic and verdict.
`timescale 1ns / 1ps
module tb_thick_stroke_quad_expander;

  localparam int CW             = tsqe_pkg::COORD_BITS_DEF;
  localparam int DRAIN_CYCLES   = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [2:0]           cfg_paddr = '0;
  logic [31:0]          cfg_pwdata = '0;
  logic [31:0]          cfg_prdata;
  logic                 cfg_pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_kind = tsqe_pkg::KIND_POINT;
  logic signed [CW-1:0] in_point_x = '0;
  logic signed [CW-1:0] in_point_y = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [CW-1:0] out_vertex_x;
  logic signed [CW-1:0] out_vertex_y;
  logic signed [15:0]   out_normal_x;
  logic signed [15:0]   out_normal_y;
  logic                 out_last_vertex;
  int                   fail_count;
  int                   pending;
  int                   points_sent = 0;
  bit                   steady = 1'b0;
  bit                   hold_req = 1'b0;

  thick_stroke_quad_expander u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_vertex_x(out_vertex_x), .out_vertex_y(out_vertex_y),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_last_vertex(out_last_vertex)
  );

  tsqe_vertex_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_vertex_x(out_vertex_x), .out_vertex_y(out_vertex_y),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_last_vertex(out_last_vertex),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_word(input logic kind, input logic [CW-1:0] x, input logic [CW-1:0] y);
    int gap;
    gap = steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_point_x <= x;
    in_point_y <= y;
    do @(posedge clk); while (!in_ready);
    if (kind == tsqe_pkg::KIND_POINT) points_sent++;
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_half_thickness(input logic [tsqe_pkg::HT_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {tsqe_pkg::REG_HALF_THICKNESS, 2'b00};
    cfg_pwdata  <= {18'($urandom), v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // start point, then steps: repeats, jumps, axis moves and small wiggles
  task automatic random_stroke(input int steps);
    logic [CW-1:0] x, y;
    int i;
    x = CW'($urandom);
    y = CW'($urandom);
    push_word(tsqe_pkg::KIND_POINT, x, y);
    for (i = 0; i < steps; i++) begin
      case ($urandom_range(0, 9))
        0: ;
        1: begin
          x = CW'($urandom);
          y = CW'($urandom);
        end
        2: x = x + CW'($urandom_range(0, 4096)) - CW'(2048);
        3: y = y + CW'($urandom_range(0, 4096)) - CW'(2048);
        default: begin
          x = x + CW'($urandom_range(0, 512)) - CW'(256);
          y = y + CW'($urandom_range(0, 512)) - CW'(256);
        end
      endcase
      push_word(tsqe_pkg::KIND_POINT, x, y);
    end
    if ($urandom_range(0, 9) < 8)
      push_word(tsqe_pkg::KIND_END, CW'($urandom), CW'($urandom));
  endtask

  task automatic random_traffic(input int n_points);
    int target;
    target = points_sent + n_points;
    while (points_sent < target) begin
      if ($urandom_range(0, 9) < 8)
        random_stroke($urandom_range(1, 6));
      else
        push_word($urandom_range(0, 1) ? tsqe_pkg::KIND_END : tsqe_pkg::KIND_POINT,
                  CW'($urandom), CW'($urandom));
    end
  endtask

  initial begin : receiver
    int run;
    bit lvl;
    run = 0;
    lvl = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        run = 0;
      end
      if (run == 0) begin
        lvl = ($urandom_range(0, 3) != 0);
        run = lvl ? $urandom_range(1, 30) : 1 + idle_gap();
      end
      out_ready <= lvl;
      run--;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset thickness: empty-stroke marks, repeats, axis and extreme segments
    push_word(tsqe_pkg::KIND_END, 16'h0000, 16'h0000);
    push_word(tsqe_pkg::KIND_POINT, 16'h0000, 16'h0000);
    push_word(tsqe_pkg::KIND_END, 16'hffff, 16'hffff);
    push_word(tsqe_pkg::KIND_POINT, 16'h0000, 16'h0000);
    push_word(tsqe_pkg::KIND_POINT, 16'h4000, 16'h0000);
    push_word(tsqe_pkg::KIND_POINT, 16'h4000, 16'h4000);
    push_word(tsqe_pkg::KIND_POINT, 16'h8000, 16'h8000);
    push_word(tsqe_pkg::KIND_POINT, 16'h7fff, 16'h8000);
    push_word(tsqe_pkg::KIND_POINT, 16'h7fff, 16'h7fff);
    push_word(tsqe_pkg::KIND_POINT, 16'h8000, 16'h7fff);
    push_word(tsqe_pkg::KIND_POINT, 16'h8001, 16'h7fff);
    push_word(tsqe_pkg::KIND_END, 16'hffff, 16'hffff);
    push_word(tsqe_pkg::KIND_END, 16'h0000, 16'h0000);
    push_word(tsqe_pkg::KIND_POINT, 16'h7fff, 16'h7fff);
    push_word(tsqe_pkg::KIND_POINT, 16'h7ffe, 16'h7fff);
    push_word(tsqe_pkg::KIND_POINT, 16'h0001, 16'h0002);
    push_word(tsqe_pkg::KIND_END, 16'h5555, 16'haaaa);
    drain_and_idle();

    // widest stroke, saturating at the coordinate limits
    write_half_thickness(14'h3fff);
    push_word(tsqe_pkg::KIND_POINT, 16'h7fff, 16'h7fff);
    push_word(tsqe_pkg::KIND_POINT, 16'h7fff, 16'h8000);
    push_word(tsqe_pkg::KIND_POINT, 16'h8000, 16'h8000);
    push_word(tsqe_pkg::KIND_END, 16'h0000, 16'h0000);
    random_traffic(20);
    drain_and_idle();

    write_half_thickness(14'h0000);
    random_traffic(15);
    drain_and_idle();

    write_half_thickness(tsqe_pkg::HT_W'($urandom));
    steady = 1'b1;
    random_traffic(10);
    hold_req <= 1'b1;
    random_traffic(10);
    steady = 1'b0;
    random_traffic(15);
    drain_and_idle();

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
